// ----- hw/rtl/escaped_frame_deframer_crc16_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame deframer
// Clocked property checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`define ESCAPED_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`ifndef ASSERT_OFF
// check outside reset
`define EFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check at every edge, reset included
`define EFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFD_ASSERT(name, prop, msg)
`define EFD_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- hw/rtl/efd_pkg.sv -----
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types, codes and the CRC-16 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int MAX_PAYLOAD = 4095;
  localparam int HEADER_LEN  = 10;
  localparam int FIXED_LEN   = 12;
  localparam int BODY_W      = 13;
  localparam logic [BODY_W-1:0] BODY_SAT = '1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] HEAD_RESET = 8'h7e;
  localparam logic [7:0] TAIL_RESET = 8'h0d;
  localparam logic [7:0] ESC_RESET  = 8'h14;

  // configuration register indexes
  localparam logic [1:0] REG_HEAD = 2'd0;
  localparam logic [1:0] REG_TAIL = 2'd1;
  localparam logic [1:0] REG_ESC  = 2'd2;

  // token kinds, front to back
  localparam logic [1:0] TK_OPEN  = 2'd0;
  localparam logic [1:0] TK_ABORT = 2'd1;
  localparam logic [1:0] TK_TAIL  = 2'd2;
  localparam logic [1:0] TK_DATA  = 2'd3;

  // end item status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CRC      = 3'd1;
  localparam logic [2:0] ST_LEN_CHK  = 3'd2;
  localparam logic [2:0] ST_LEN_MISS = 3'd3;
  localparam logic [2:0] ST_FORMAT   = 3'd4;
  localparam logic [2:0] ST_ABORT    = 3'd5;

  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_END     = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic       esc;   // escape was pending when the tail arrived
    logic [7:0] data;  // unescaped byte
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  version;
    logic [31:0] address;
    logic [7:0]  sub_id;
    logic [7:0]  command_group;
    logic [7:0]  command_code;
    logic [11:0] payload_count;
    logic [2:0]  status;
    logic        frame_end;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/efd_front.sv -----
// ----------------------------------------------------------------------------
// efd_front
// Holds the marker registers, tracks frame and escape state, and turns raw
// link bytes into tokens for the back end.
// ----------------------------------------------------------------------------
module efd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  efd_pkg::qstat_t  qstat,
  output logic             push,
  output efd_pkg::token_t  push_tok
);
  import efd_pkg::*;

  logic [7:0] head_byte;
  logic [7:0] tail_byte;
  logic [7:0] escape_byte;
  logic       in_frame;
  logic       in_frame_next;
  logic       esc_pending;
  logic       esc_pending_next;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !qstat.full;
  assign accept    = in_valid && in_ready;

  // head beats tail, tail beats escape
  always_comb begin
    push             = 1'b0;
    push_tok.kind    = TK_DATA;
    push_tok.esc     = esc_pending;
    push_tok.data    = in_byte;
    in_frame_next    = in_frame;
    esc_pending_next = esc_pending;
    if (accept) begin
      if (!in_frame) begin
        if (in_byte == head_byte) begin
          push             = 1'b1;
          push_tok.kind    = TK_OPEN;
          in_frame_next    = 1'b1;
          esc_pending_next = 1'b0;
        end
      end else if (in_byte == head_byte) begin
        push             = 1'b1;
        push_tok.kind    = TK_ABORT;
        esc_pending_next = 1'b0;
      end else if (in_byte == tail_byte) begin
        push             = 1'b1;
        push_tok.kind    = TK_TAIL;
        in_frame_next    = 1'b0;
        esc_pending_next = 1'b0;
      end else if (esc_pending) begin
        push             = 1'b1;
        push_tok.data    = ~in_byte;
        esc_pending_next = 1'b0;
      end else if (in_byte == escape_byte) begin
        esc_pending_next = 1'b1;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte   <= HEAD_RESET;
      tail_byte   <= TAIL_RESET;
      escape_byte <= ESC_RESET;
      in_frame    <= 1'b0;
      esc_pending <= 1'b0;
    end else begin
      in_frame    <= in_frame_next;
      esc_pending <= esc_pending_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HEAD: head_byte   <= cfg_data;
          REG_TAIL: tail_byte   <= cfg_data;
          REG_ESC:  escape_byte <= cfg_data;
          default:  ;
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/efd_queue.sv -----
// ----------------------------------------------------------------------------
// efd_queue
// Small token queue between front and back end.
// ----------------------------------------------------------------------------
`include "escaped_frame_deframer_crc16_assert.svh"

module efd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  efd_pkg::token_t  push_tok,
  input  logic             pop,
  output efd_pkg::token_t  pop_tok,
  output efd_pkg::qstat_t  qstat
);
  import efd_pkg::*;

  token_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign qstat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign pop_tok     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `EFD_ASSERT(a_no_overflow, !(push && qstat.full && !pop), "token pushed into full queue")
  `EFD_ASSERT(a_no_underflow, !(pop && qstat.empty), "token popped from empty queue")
  `EFD_ASSERT(a_count_bound, count <= (QPTR_W+1)'(QDEPTH), "queue count out of range")

endmodule

// ----- hw/rtl/efd_back.sv -----
// ----------------------------------------------------------------------------
// efd_back
// Frame body processing: header capture, CRC, payload emission and the
// end-of-frame checks, with a registered result slot.
// ----------------------------------------------------------------------------
module efd_back (
  input  logic             clk,
  input  logic             rst,
  input  efd_pkg::qstat_t  qstat,
  input  efd_pkg::token_t  tok,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output efd_pkg::result_t out_res
);
  import efd_pkg::*;

  localparam logic [BODY_W-1:0] BODY_MAX = BODY_W'(FIXED_LEN + MAX_PAYLOAD);

  logic [BODY_W-1:0] body_count;
  logic [15:0]       running_crc;
  logic [7:0]        held0;
  logic [7:0]        held1;
  logic [7:0]        hdr [HEADER_LEN];
  logic              format_fault;

  logic [BODY_W-1:0] count_inc;
  logic [BODY_W-1:0] pos;
  logic [BODY_W-1:0] seen_diff;
  logic [11:0]       lenid;
  logic [11:0]       seen;
  logic [5:0]        nib_sum;
  logic [5:0]        nib_neg;
  logic              emit_pay;
  logic [2:0]        tail_status;
  logic              has_res;
  result_t           res;

  assign pop = !qstat.empty && (!out_valid || out_ready);

  assign count_inc = (body_count == BODY_SAT) ? body_count : body_count + 1'b1;
  assign lenid     = {hdr[8][3:0], hdr[9]};
  assign pos       = body_count - BODY_W'(HEADER_LEN);
  assign emit_pay  = (body_count >= BODY_W'(HEADER_LEN)) && (pos < {1'b0, lenid}) &&
                     (pos < BODY_W'(MAX_PAYLOAD));

  // payload bytes seen so far, saturated to 12 bits
  assign seen_diff = body_count - BODY_W'(FIXED_LEN);
  always_comb begin
    if (body_count < BODY_W'(FIXED_LEN)) begin
      seen = '0;
    end else if (seen_diff[BODY_W-1]) begin
      seen = '1;
    end else begin
      seen = seen_diff[11:0];
    end
  end

  assign nib_sum = {2'b00, hdr[8][3:0]} + {2'b00, hdr[9][7:4]} + {2'b00, hdr[9][3:0]};
  assign nib_neg = ~nib_sum + 6'd1;

  always_comb begin
    if (tok.esc || format_fault || body_count < BODY_W'(FIXED_LEN) ||
        body_count > BODY_MAX) begin
      tail_status = ST_FORMAT;
    end else if ({held0, held1} != running_crc) begin
      tail_status = ST_CRC;
    end else if (hdr[8][7:4] != nib_neg[3:0]) begin
      tail_status = ST_LEN_CHK;
    end else if (lenid != seen) begin
      tail_status = ST_LEN_MISS;
    end else begin
      tail_status = ST_OK;
    end
  end

  always_comb begin
    res               = '0;
    res.item_kind     = ITEM_END;
    res.version       = hdr[0];
    res.address       = {hdr[1], hdr[2], hdr[3], hdr[4]};
    res.sub_id        = hdr[5];
    res.command_group = hdr[6];
    res.command_code  = hdr[7];
    res.payload_count = seen;
    res.status        = (tok.kind == TK_ABORT) ? ST_ABORT : tail_status;
    res.frame_end     = 1'b1;
    has_res           = 1'b0;
    unique case (tok.kind) inside
      TK_ABORT, TK_TAIL: has_res = 1'b1;
      TK_DATA: begin
        if (emit_pay) begin
          has_res          = 1'b1;
          res              = '0;
          res.item_kind    = ITEM_PAYLOAD;
          res.payload_byte = tok.data;
        end
      end
      default: has_res = 1'b0;
    endcase
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      body_count   <= '0;
      running_crc  <= '0;
      held0        <= '0;
      held1        <= '0;
      format_fault <= 1'b0;
      for (int i = 0; i < HEADER_LEN; i++) begin
        hdr[i] <= '0;
      end
    end else if (pop) begin
      unique case (tok.kind) inside
        TK_OPEN, TK_ABORT: begin
          body_count   <= '0;
          running_crc  <= '0;
          held0        <= '0;
          held1        <= '0;
          format_fault <= 1'b0;
          for (int i = 0; i < HEADER_LEN; i++) begin
            hdr[i] <= '0;
          end
        end
        TK_DATA: begin
          // the two newest bytes wait in held0/held1 before entering the CRC
          if (body_count >= BODY_W'(2)) begin
            running_crc <= crc_byte(running_crc, held0);
          end
          held0      <= held1;
          held1      <= tok.data;
          body_count <= count_inc;
          if (count_inc > BODY_MAX) begin
            format_fault <= 1'b1;
          end
          if (body_count < BODY_W'(HEADER_LEN)) begin
            hdr[body_count[3:0]] <= tok.data;
          end
        end
        default: ;
      endcase
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= has_res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      out_res <= res;
    end
  end

endmodule

// ----- hw/rtl/escaped_frame_deframer_crc16.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_deframer_crc16
// Byte-stuffed frame deframer with CRC-16/XMODEM and length checks.
// ----------------------------------------------------------------------------
// Takes one raw link byte per clock while the queue is not full. The front
// end classifies each byte against the marker registers in the cycle it is
// accepted and writes a token into a four-entry queue. The back end retires
// one token per cycle unless its output register holds an untaken item,
// doing the CRC-16 byte update combinationally, with the result registered.
// Items pass a queue slot, then the output register. Output back-pressure
// fills the queue; s_axis_tready drops only once all four slots are taken.
module escaped_frame_deframer_crc16 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [15:8] version, [47:16] address, [55:48] sub_id,
  // [63:56] command_group, [71:64] command_code, [83:72] payload_count,
  // [86:84] status, [87] zero
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] item_kind
  output logic        m_axis_tlast    // frame_end
);
  import efd_pkg::*;

  qstat_t  qstat;
  token_t  push_tok;
  token_t  pop_tok;
  result_t res;
  logic    push;
  logic    pop;

  efd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .qstat     (qstat),
    .push      (push),
    .push_tok  (push_tok)
  );

  efd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .qstat    (qstat)
  );

  efd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .tok       (pop_tok),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {1'b0, res.status, res.payload_count, res.command_code,
                         res.command_group, res.sub_id, res.address, res.version,
                         res.payload_byte};
  assign m_axis_tuser = res.item_kind;
  assign m_axis_tlast = res.frame_end;

endmodule
